// ----- rtl/c2dcd_pkg.sv -----
// ----------------------------------------------------------------------------
// c2dcd_pkg
// shared types, sizes and codes of the decimated complex 2d correlator
// ----------------------------------------------------------------------------
`default_nettype none

package c2dcd_pkg;

  localparam int IMAGE_WIDTH     = 64;
  localparam int IMAGE_HEIGHT    = 64;
  localparam int KERNEL_MAX_COLS = 16;
  localparam int KERNEL_MAX_ROWS = 16;

  localparam int KER_DEPTH = KERNEL_MAX_ROWS * KERNEL_MAX_COLS;
  localparam int IMG_DEPTH = IMAGE_HEIGHT * IMAGE_WIDTH;
  localparam int KER_AW    = $clog2(KER_DEPTH);
  localparam int IMG_AW    = $clog2(IMG_DEPTH);
  localparam int KMAX      = (KERNEL_MAX_ROWS > KERNEL_MAX_COLS) ?
                             KERNEL_MAX_ROWS : KERNEL_MAX_COLS;
  localparam int KCNT_W    = $clog2(KMAX + 1);

  localparam int POS_W    = 6;
  localparam int SAMPLE_W = 16;
  localparam int ELEM_W   = 2 * SAMPLE_W;
  localparam int ACC_W    = 48;
  localparam int STEP_W   = 4;
  localparam int KSIZE_W  = 5;
  localparam int OSIZE_W  = 7;
  // window origin plus kernel size, never wraps
  localparam int RC_W     = POS_W + STEP_W + 1;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DW    = 7;
  localparam int S_DATA_W  = 48;
  localparam int M_DATA_W  = 112;

  localparam logic [CFG_IDX_W-1:0] REG_CONJ        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_X      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Y      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_COLS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ROWS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_COLS    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_ROWS    = 3'd6;

  typedef enum logic [1:0] {
    KIND_KERNEL  = 2'd0,
    KIND_IMAGE   = 2'd1,
    KIND_COMPUTE = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHECK,
    ST_RUN,
    ST_FLUSH,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic               conj;
    logic [STEP_W-1:0]  step_x;
    logic [STEP_W-1:0]  step_y;
    logic [KSIZE_W-1:0] kernel_cols;
    logic [KSIZE_W-1:0] kernel_rows;
    logic [OSIZE_W-1:0] out_cols;
    logic [OSIZE_W-1:0] out_rows;
  } cfg_t;

  typedef struct packed {
    logic              kwe;
    logic              iwe;
    logic [KER_AW-1:0] kaddr;
    logic [IMG_AW-1:0] iaddr;
    logic [ELEM_W-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic              en;
    logic [KER_AW-1:0] kaddr;
    logic [IMG_AW-1:0] iaddr;
  } mem_rd_t;

  typedef struct packed {
    logic             load;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             status;
    logic             last;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/c2dcd_mem.sv -----
// ----------------------------------------------------------------------------
// c2dcd_mem
// kernel and image sample stores, one write and one registered read each
// ----------------------------------------------------------------------------
`default_nettype none

module c2dcd_mem (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire c2dcd_pkg::mem_wr_t        wr,
  input  wire c2dcd_pkg::mem_rd_t        rd,
  output logic                           rd_valid,
  output logic [c2dcd_pkg::ELEM_W-1:0]   ker_data,
  output logic [c2dcd_pkg::ELEM_W-1:0]   img_data
);
  import c2dcd_pkg::*;

  logic [ELEM_W-1:0] ker_mem [KER_DEPTH];
  logic [ELEM_W-1:0] img_mem [IMG_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.kwe) begin
      ker_mem[wr.kaddr] <= wr.data;
    end
    if (rd.en) begin
      ker_data <= ker_mem[rd.kaddr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.iwe) begin
      img_mem[wr.iaddr] <= wr.data;
    end
    if (rd.en) begin
      img_data <= img_mem[rd.iaddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= rd.en;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/c2dcd_mac.sv -----
// ----------------------------------------------------------------------------
// c2dcd_mac
// complex multiply with optional image conjugate, then 48-bit accumulate
// ----------------------------------------------------------------------------
`default_nettype none

module c2dcd_mac (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             conj,
  input  wire logic                             acc_clr,
  input  wire logic                             rd_valid,
  input  wire logic [c2dcd_pkg::ELEM_W-1:0]     img_data,
  input  wire logic [c2dcd_pkg::ELEM_W-1:0]     ker_data,
  output logic                                  busy,
  output logic signed [c2dcd_pkg::ACC_W-1:0]    acc_re,
  output logic signed [c2dcd_pkg::ACC_W-1:0]    acc_im
);
  import c2dcd_pkg::*;

  logic signed [SAMPLE_W-1:0]   ar;
  logic signed [SAMPLE_W:0]     ai_s;
  logic signed [SAMPLE_W:0]     ai;
  logic signed [SAMPLE_W-1:0]   br;
  logic signed [SAMPLE_W-1:0]   bi;
  logic signed [2*SAMPLE_W-1:0] p_rr;
  logic signed [2*SAMPLE_W-1:0] p_ri;
  logic signed [2*SAMPLE_W:0]   p_ii;
  logic signed [2*SAMPLE_W:0]   p_ir;
  logic                         p_valid;

  always_comb begin
    ar   = $signed(img_data[SAMPLE_W-1:0]);
    ai_s = $signed({img_data[ELEM_W-1], img_data[ELEM_W-1:SAMPLE_W]});
    ai   = conj ? -ai_s : ai_s;
    br   = $signed(ker_data[SAMPLE_W-1:0]);
    bi   = $signed(ker_data[ELEM_W-1:SAMPLE_W]);
  end

  always_ff @(posedge clk) begin
    p_rr <= ar * br;
    p_ri <= ar * bi;
    p_ii <= ai * bi;
    p_ir <= ai * br;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= rd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_clr) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (p_valid) begin
      acc_re <= acc_re + ACC_W'(p_rr) - ACC_W'(p_ii);
      acc_im <= acc_im + ACC_W'(p_ri) + ACC_W'(p_ir);
    end
  end

  assign busy = rd_valid | p_valid;

endmodule

`default_nettype wire

// ----- rtl/c2dcd_seq.sv -----
// ----------------------------------------------------------------------------
// c2dcd_seq
// input handshake, store writes, range checks and kernel window walk
// ----------------------------------------------------------------------------
`default_nettype none

module c2dcd_seq (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire c2dcd_pkg::cfg_t               cfg,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_kind,
  input  wire logic [c2dcd_pkg::POS_W-1:0]   in_row,
  input  wire logic [c2dcd_pkg::POS_W-1:0]   in_col,
  input  wire logic [c2dcd_pkg::ELEM_W-1:0]  in_value,
  input  wire logic                          busy,
  input  wire logic                          out_free,
  output c2dcd_pkg::mem_wr_t                 wr,
  output c2dcd_pkg::mem_rd_t                 rd,
  output logic                               acc_clr,
  output c2dcd_pkg::res_t                    res
);
  import c2dcd_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [POS_W-1:0]  row_q;
  logic [POS_W-1:0]  col_q;
  logic [RC_W-1:0]   r0_q;
  logic [RC_W-1:0]   c0_q;
  logic [KCNT_W-1:0] kr_q;
  logic [KCNT_W-1:0] kc_q;
  logic [KCNT_W-1:0] k_q;
  logic [KCNT_W-1:0] l_q;
  logic [KER_AW-1:0] kbase_q;
  logic [IMG_AW-1:0] ibase_q;
  logic              err_q;
  logic              accept;
  logic              err_now;
  logic              row_end;
  logic              last_row;

  assign accept   = in_valid && in_ready;
  assign row_end  = (l_q == kc_q - KCNT_W'(1));
  assign last_row = (k_q == kr_q - KCNT_W'(1));

  always_comb begin
    err_now = ({1'b0, row_q} >= cfg.out_rows) || ({1'b0, col_q} >= cfg.out_cols) ||
              ((r0_q + RC_W'(kr_q)) > IMAGE_HEIGHT) ||
              ((c0_q + RC_W'(kc_q)) > IMAGE_WIDTH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    acc_clr    = 1'b0;
    rd.en      = 1'b0;
    rd.kaddr   = kbase_q + KER_AW'(l_q);
    rd.iaddr   = ibase_q + IMG_AW'(l_q);
    wr.kwe     = 1'b0;
    wr.iwe     = 1'b0;
    wr.kaddr   = KER_AW'(in_row * KERNEL_MAX_COLS + in_col);
    wr.iaddr   = IMG_AW'(in_row * IMAGE_WIDTH + in_col);
    wr.data    = in_value;
    res.load   = 1'b0;
    res.row    = row_q;
    res.col    = col_q;
    res.status = err_q;
    res.last   = !err_q && (({1'b0, row_q} + OSIZE_W'(1)) == cfg.out_rows) &&
                 (({1'b0, col_q} + OSIZE_W'(1)) == cfg.out_cols);
    case (state)
      ST_IDLE: begin
        in_ready = !rst;
        if (accept) begin
          case (in_kind)
            KIND_KERNEL: begin
              wr.kwe = (in_row < KERNEL_MAX_ROWS) && (in_col < KERNEL_MAX_COLS);
            end
            KIND_IMAGE: begin
              wr.iwe = (in_row < IMAGE_HEIGHT) && (in_col < IMAGE_WIDTH);
            end
            KIND_COMPUTE: begin
              state_next = ST_MUL;
            end
            default: ;
          endcase
        end
      end
      ST_MUL: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        acc_clr = 1'b1;
        if (err_now || kr_q == '0 || kc_q == '0) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        rd.en = 1'b1;
        if (row_end && last_row) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!busy) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          res.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        row_q <= in_row;
        col_q <= in_col;
      end
      ST_MUL: begin
        r0_q <= RC_W'(row_q) * RC_W'(cfg.step_y);
        c0_q <= RC_W'(col_q) * RC_W'(cfg.step_x);
        kr_q <= (cfg.kernel_rows > KERNEL_MAX_ROWS) ? KCNT_W'(KERNEL_MAX_ROWS)
                                                    : KCNT_W'(cfg.kernel_rows);
        kc_q <= (cfg.kernel_cols > KERNEL_MAX_COLS) ? KCNT_W'(KERNEL_MAX_COLS)
                                                    : KCNT_W'(cfg.kernel_cols);
      end
      ST_CHECK: begin
        err_q   <= err_now;
        k_q     <= '0;
        l_q     <= '0;
        kbase_q <= '0;
        ibase_q <= IMG_AW'(r0_q * IMAGE_WIDTH + c0_q);
      end
      ST_RUN: begin
        if (row_end) begin
          l_q     <= '0;
          k_q     <= k_q + KCNT_W'(1);
          kbase_q <= KER_AW'(kbase_q + KERNEL_MAX_COLS);
          ibase_q <= IMG_AW'(ibase_q + IMAGE_WIDTH);
        end else begin
          l_q <= l_q + KCNT_W'(1);
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/complex_2d_correlation_decimated_top.sv -----
// ----------------------------------------------------------------------------
// complex_2d_correlation_decimated_top
// decimated complex 2d correlation over on-chip kernel and image stores
// ----------------------------------------------------------------------------
// channel  dir  payload
// s_*      in   tuser: kind; tdata: row, col, value_re, value_im
// m_*      out  tuser: status; tlast: last; tdata: out_row, out_col,
//                result_re, result_im
// cfg_*    in   register index and write data, no read-back
//
// a load beat writes one store entry when its row and col are in range; a compute
// beat reads one kernel and one image sample per cycle from the stores over the window
// an out-of-range point skips the store reads and returns an error status
// reset clears control and configuration; store contents stay unknown
// a held result in the output register does not stall the next load beat
// ----------------------------------------------------------------------------
`default_nettype none

module complex_2d_correlation_decimated_top (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [c2dcd_pkg::S_DATA_W-1:0]     s_tdata,  // row, col, value_re, value_im
  input  wire logic [1:0]                         s_tuser,  // kind
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic [c2dcd_pkg::M_DATA_W-1:0]          m_tdata,  // out_row, out_col, result_re, result_im
  output logic                                    m_tuser,  // status
  output logic                                    m_tlast,
  input  wire logic                               cfg_we,
  input  wire logic [c2dcd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [c2dcd_pkg::CFG_DW-1:0]       cfg_data
);
  import c2dcd_pkg::*;

  cfg_t                     cfg;
  mem_wr_t                  wr;
  mem_rd_t                  rd;
  res_t                     res;
  logic                     rd_valid;
  logic [ELEM_W-1:0]        ker_data;
  logic [ELEM_W-1:0]        img_data;
  logic                     busy;
  logic                     acc_clr;
  logic                     out_free;
  logic signed [ACC_W-1:0]  acc_re;
  logic signed [ACC_W-1:0]  acc_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.conj        <= 1'b0;
      cfg.step_x      <= STEP_W'(1);
      cfg.step_y      <= STEP_W'(1);
      cfg.kernel_cols <= KSIZE_W'(1);
      cfg.kernel_rows <= KSIZE_W'(1);
      cfg.out_cols    <= OSIZE_W'(1);
      cfg.out_rows    <= OSIZE_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CONJ:        cfg.conj        <= cfg_data[0];
        REG_STEP_X:      cfg.step_x      <= cfg_data[STEP_W-1:0];
        REG_STEP_Y:      cfg.step_y      <= cfg_data[STEP_W-1:0];
        REG_KERNEL_COLS: cfg.kernel_cols <= cfg_data[KSIZE_W-1:0];
        REG_KERNEL_ROWS: cfg.kernel_rows <= cfg_data[KSIZE_W-1:0];
        REG_OUT_COLS:    cfg.out_cols    <= cfg_data[OSIZE_W-1:0];
        REG_OUT_ROWS:    cfg.out_rows    <= cfg_data[OSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  c2dcd_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_kind  (s_tuser),
    .in_row   (s_tdata[POS_W-1:0]),
    .in_col   (s_tdata[2*POS_W-1:POS_W]),
    .in_value (s_tdata[2*POS_W+ELEM_W-1:2*POS_W]),
    .busy     (busy),
    .out_free (out_free),
    .wr       (wr),
    .rd       (rd),
    .acc_clr  (acc_clr),
    .res      (res)
  );

  c2dcd_mem u_mem (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .rd       (rd),
    .rd_valid (rd_valid),
    .ker_data (ker_data),
    .img_data (img_data)
  );

  c2dcd_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .conj     (cfg.conj),
    .acc_clr  (acc_clr),
    .rd_valid (rd_valid),
    .img_data (img_data),
    .ker_data (ker_data),
    .busy     (busy),
    .acc_re   (acc_re),
    .acc_im   (acc_im)
  );

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      m_tdata <= {(M_DATA_W - 2*POS_W - 2*ACC_W)'(0), acc_im, acc_re, res.col, res.row};
      m_tuser <= res.status;
      m_tlast <= res.last;
    end
  end

endmodule

`default_nettype wire
